>>> rtl/vdz_pkg.sv
`timescale 1ns / 1ps
// Shared types, opcodes and defaults for the dead-zone engine.
package vdz_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int IDS_DEF   = 16;
    localparam int XW        = 32;
    localparam int OPW       = 3;
    localparam int SLOTW     = 4;
    localparam int ZCW       = 5;
    localparam int QDEPTH    = 2;
    localparam int QPW       = 1;
    localparam int QCW       = 2;

    localparam logic [OPW-1:0] OP_CLEAR   = 3'd0;
    localparam logic [OPW-1:0] OP_ADD     = 3'd1;
    localparam logic [OPW-1:0] OP_BOUND   = 3'd2;
    localparam logic [OPW-1:0] OP_COMPUTE = 3'd3;
    localparam logic [OPW-1:0] OP_QUERY   = 3'd4;
    localparam logic [OPW-1:0] OP_NOP     = 3'd7;

    typedef struct packed {
        logic [OPW-1:0]   op;
        logic             slot_ok;
        logic [SLOTW-1:0] slot;
        logic [XW-1:0]    xid;
        logic [XW-1:0]    bound;
        logic [XW-1:0]    vbegin;
        logic [XW-1:0]    vend;
        logic [XW-1:0]    oldest;
    } t_cmd;

endpackage

>>> rtl/vdz_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module vdz_ram #(
    parameter int W = 32,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/vdz_front.sv
`timescale 1ns / 1ps
// Front end: accepts transactions, classifies them and queues them for the engine.
module vdz_front #(
    parameter int SLOTS = vdz_pkg::SLOTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic [vdz_pkg::OPW-1:0]    i_op,
    input  logic [vdz_pkg::SLOTW-1:0]  i_slot,
    input  logic [vdz_pkg::XW-1:0]     i_active_xid,
    input  logic [vdz_pkg::XW-1:0]     i_snapshot_bound,
    input  logic [vdz_pkg::XW-1:0]     i_version_begin,
    input  logic [vdz_pkg::XW-1:0]     i_version_end,
    input  logic [vdz_pkg::XW-1:0]     i_global_oldest,
    output logic                       o_cmd_vld,
    output vdz_pkg::t_cmd              o_cmd,
    input  logic                       i_pop
);
    import vdz_pkg::*;

    t_cmd             r_q [QDEPTH];
    logic [QPW-1:0]   r_wp;
    logic [QPW-1:0]   r_rp;
    logic [QCW-1:0]   r_cnt;
    t_cmd             n_cmd;
    logic [OPW-1:0]   op_cls;
    logic [8:0]       slot9;
    logic             push;

    always_comb begin
        unique case (i_op) inside
            OP_CLEAR, OP_ADD, OP_BOUND, OP_COMPUTE, OP_QUERY: op_cls = i_op;
            default: op_cls = OP_NOP;
        endcase
    end

    assign slot9         = 9'(i_slot);
    assign n_cmd.op      = op_cls;
    assign n_cmd.slot_ok = (slot9 < 9'(SLOTS));
    assign n_cmd.slot    = i_slot;
    assign n_cmd.xid     = i_active_xid;
    assign n_cmd.bound   = i_snapshot_bound;
    assign n_cmd.vbegin  = i_version_begin;
    assign n_cmd.vend    = i_version_end;
    assign n_cmd.oldest  = i_global_oldest;

    assign o_busy    = (r_cnt == QCW'(QDEPTH));
    assign push      = i_start && !o_busy;
    assign o_cmd_vld = (r_cnt != '0);
    assign o_cmd     = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCW'(QDEPTH)) else $error("queue count overflow");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != '0) else $error("pop from empty queue");
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_pop) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("push lost");
endmodule

>>> rtl/vdz_back.sv
`timescale 1ns / 1ps
// Back end: executes table updates, the zone build and queries over the RAMs.
module vdz_back #(
    parameter int SLOTS        = vdz_pkg::SLOTS_DEF,
    parameter int IDS_PER_SLOT = vdz_pkg::IDS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cmd_vld,
    input  vdz_pkg::t_cmd           i_cmd,
    output logic                    o_pop,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [vdz_pkg::XW-1:0]  i_cfg_data,
    output logic                    o_done,
    output logic                    o_status,
    output logic                    o_is_dead,
    output logic [vdz_pkg::ZCW-1:0] o_zone_count
);
    import vdz_pkg::*;

    localparam int SW  = $clog2(SLOTS);
    localparam int ZW  = $clog2(SLOTS + 1);
    localparam int CW  = $clog2(IDS_PER_SLOT + 1);
    localparam int AW  = $clog2(SLOTS * IDS_PER_SLOT);
    localparam int EW  = CW + XW;
    localparam int STW = 5;

    localparam logic [STW-1:0] S_IDLE   = 5'd0;
    localparam logic [STW-1:0] S_DISP   = 5'd1;
    localparam logic [STW-1:0] S_RMW    = 5'd2;
    localparam logic [STW-1:0] S_INIT   = 5'd3;
    localparam logic [STW-1:0] S_OSTART = 5'd4;
    localparam logic [STW-1:0] S_OADR   = 5'd5;
    localparam logic [STW-1:0] S_ORD    = 5'd6;
    localparam logic [STW-1:0] S_ENT    = 5'd7;
    localparam logic [STW-1:0] S_SWAP1  = 5'd8;
    localparam logic [STW-1:0] S_SWAP2  = 5'd9;
    localparam logic [STW-1:0] S_OEND   = 5'd10;
    localparam logic [STW-1:0] S_ZOADR  = 5'd11;
    localparam logic [STW-1:0] S_ZORD   = 5'd12;
    localparam logic [STW-1:0] S_ZENT   = 5'd13;
    localparam logic [STW-1:0] S_SCAN   = 5'd14;
    localparam logic [STW-1:0] S_ZWR    = 5'd15;
    localparam logic [STW-1:0] S_QRY    = 5'd16;

    logic [STW-1:0]   r_st;
    t_cmd             r_cmd;
    logic [XW-1:0]    r_defer;
    logic [SLOTS-1:0] r_vld;
    logic             r_evld;
    logic [ZW-1:0]    r_i;
    logic [SW-1:0]    r_j;
    logic [SW-1:0]    r_pick;
    logic [SW-1:0]    r_pick_s;
    logic [SW-1:0]    r_si;
    logic [SW-1:0]    r_s;
    logic [XW-1:0]    r_least;
    logic [XW-1:0]    r_lo;
    logic [XW-1:0]    r_best;
    logic [XW-1:0]    r_curb;
    logic [XW-1:0]    r_prevb;
    logic [CW-1:0]    r_n;
    logic [CW-1:0]    r_k;
    logic             r_kv;
    logic [ZW-1:0]    r_qi;
    logic             r_qv;
    logic [ZW-1:0]    r_zones;
    logic             r_done;
    logic             r_status;
    logic             r_dead;

    logic [8:0]       slot9;
    logic [SW-1:0]    slot_idx;
    logic [SW-1:0]    ri_idx;
    logic             ord_we;
    logic [SW-1:0]    ord_waddr;
    logic [SW-1:0]    ord_wdata;
    logic [SW-1:0]    ord_raddr;
    logic [SW-1:0]    ord_rdata;
    logic             ent_we;
    logic [SW-1:0]    ent_raddr;
    logic [EW-1:0]    ent_wdata;
    logic [EW-1:0]    ent_rdata;
    logic [CW-1:0]    e_cnt;
    logic [XW-1:0]    e_bnd;
    logic             full;
    logic             id_we;
    logic [AW-1:0]    id_waddr;
    logic [AW-1:0]    id_raddr;
    logic [XW-1:0]    id_rdata;
    logic             zn_we;
    logic [2*XW-1:0]  zn_rdata;
    logic [XW-1:0]    limit;
    logic             q_hit;
    logic             k_hit;
    logic [31:0]      zc32;

    assign slot9    = 9'(r_cmd.slot);
    assign slot_idx = slot9[SW-1:0];
    assign ri_idx   = r_i[SW-1:0];
    assign e_cnt    = r_evld ? ent_rdata[EW-1:XW] : '0;
    assign e_bnd    = r_evld ? ent_rdata[XW-1:0] : '0;
    assign full     = (e_cnt >= CW'(IDS_PER_SLOT));
    assign limit    = r_cmd.oldest + r_defer;
    assign q_hit    = r_qv && (r_cmd.vbegin > zn_rdata[2*XW-1:XW])
                      && (r_cmd.vend < zn_rdata[XW-1:0]);
    assign k_hit    = r_kv && (id_rdata > r_lo) && (id_rdata < r_best);
    assign id_waddr = AW'(slot_idx) * AW'(IDS_PER_SLOT) + AW'(e_cnt);
    assign id_raddr = AW'(r_s) * AW'(IDS_PER_SLOT) + AW'(r_k);
    assign id_we    = (r_st == S_RMW) && (r_cmd.op == OP_ADD) && !full;
    assign ent_we   = (r_st == S_RMW) && !((r_cmd.op == OP_ADD) && full);
    assign ent_wdata = (r_cmd.op == OP_ADD) ? {CW'(e_cnt + 1'b1), e_bnd}
                                            : {e_cnt, r_cmd.bound};
    assign zn_we    = (r_st == S_ZWR);
    assign o_pop    = (r_st == S_IDLE) && i_cmd_vld;
    assign o_cfg_ready  = 1'b1;
    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_is_dead    = r_dead;
    assign zc32         = 32'(r_zones);
    assign o_zone_count = zc32[ZCW-1:0];

    always_comb begin
        ord_we    = 1'b0;
        ord_waddr = ri_idx;
        ord_wdata = ri_idx;
        unique case (r_st)
            S_INIT: begin
                ord_we = 1'b1;
            end
            S_SWAP1: begin
                ord_we    = (r_pick != ri_idx);
                ord_wdata = r_pick_s;
            end
            S_SWAP2: begin
                ord_we    = 1'b1;
                ord_waddr = r_pick;
                ord_wdata = r_si;
            end
            default: ord_we = 1'b0;
        endcase
    end

    assign ord_raddr = (r_st == S_ZOADR) ? ri_idx : r_j;
    assign ent_raddr = ((r_st == S_ORD) || (r_st == S_ZORD)) ? ord_rdata : slot_idx;

    vdz_ram #(.W(SW), .D(SLOTS)) u_ord (
        .i_clk(i_clk), .i_we(ord_we), .i_waddr(ord_waddr), .i_wdata(ord_wdata),
        .i_raddr(ord_raddr), .o_rdata(ord_rdata)
    );

    vdz_ram #(.W(EW), .D(SLOTS)) u_ent (
        .i_clk(i_clk), .i_we(ent_we), .i_waddr(slot_idx), .i_wdata(ent_wdata),
        .i_raddr(ent_raddr), .o_rdata(ent_rdata)
    );

    vdz_ram #(.W(XW), .D(SLOTS * IDS_PER_SLOT)) u_ids (
        .i_clk(i_clk), .i_we(id_we), .i_waddr(id_waddr), .i_wdata(r_cmd.xid),
        .i_raddr(id_raddr), .o_rdata(id_rdata)
    );

    vdz_ram #(.W(2 * XW), .D(SLOTS)) u_zone (
        .i_clk(i_clk), .i_we(zn_we), .i_waddr(ri_idx), .i_wdata({r_lo, r_best}),
        .i_raddr(r_qi[SW-1:0]), .o_rdata(zn_rdata)
    );

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_evld <= r_vld[ent_raddr];
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_defer  <= '0;
            r_vld    <= '0;
            r_zones  <= '0;
            r_done   <= 1'b0;
            r_status <= 1'b0;
            r_dead   <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_n      <= '0;
            r_kv     <= 1'b0;
            r_qi     <= '0;
            r_qv     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_valid) begin
                r_defer <= i_cfg_data;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (i_cmd_vld) begin
                        r_st <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_status <= 1'b0;
                    r_dead   <= 1'b0;
                    unique case (r_cmd.op) inside
                        OP_CLEAR: begin
                            r_vld  <= '0;
                            r_done <= 1'b1;
                            r_st   <= S_IDLE;
                        end
                        OP_ADD, OP_BOUND: begin
                            if (r_cmd.slot_ok) begin
                                r_st <= S_RMW;
                            end else begin
                                r_done <= 1'b1;
                                r_st   <= S_IDLE;
                            end
                        end
                        OP_COMPUTE: begin
                            r_i  <= '0;
                            r_st <= S_INIT;
                        end
                        OP_QUERY: begin
                            if (r_cmd.vend < limit) begin
                                r_dead <= 1'b1;
                                r_done <= 1'b1;
                                r_st   <= S_IDLE;
                            end else begin
                                r_qi <= '0;
                                r_qv <= 1'b0;
                                r_st <= S_QRY;
                            end
                        end
                        default: begin
                            r_done <= 1'b1;
                            r_st   <= S_IDLE;
                        end
                    endcase
                end
                S_RMW: begin
                    if ((r_cmd.op == OP_ADD) && full) begin
                        r_status <= 1'b1;
                    end else begin
                        r_vld[slot_idx] <= 1'b1;
                    end
                    r_done <= 1'b1;
                    r_st   <= S_IDLE;
                end
                S_INIT: begin
                    if (ri_idx == SW'(SLOTS - 1)) begin
                        r_i  <= '0;
                        r_st <= S_OSTART;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_OSTART: begin
                    r_j     <= ri_idx;
                    r_pick  <= ri_idx;
                    r_least <= '1;
                    r_st    <= S_OADR;
                end
                S_OADR: begin
                    r_st <= S_ORD;
                end
                S_ORD: begin
                    r_s  <= ord_rdata;
                    r_st <= S_ENT;
                end
                S_ENT: begin
                    if (r_j == ri_idx) begin
                        r_si <= r_s;
                    end
                    if ((e_cnt != '0) && (e_bnd < r_least)) begin
                        r_least  <= e_bnd;
                        r_pick   <= r_j;
                        r_pick_s <= r_s;
                    end
                    if (r_j == SW'(SLOTS - 1)) begin
                        r_st <= S_SWAP1;
                    end else begin
                        r_j  <= r_j + 1'b1;
                        r_st <= S_OADR;
                    end
                end
                S_SWAP1: begin
                    r_st <= (r_pick != ri_idx) ? S_SWAP2 : S_OEND;
                end
                S_SWAP2: begin
                    r_st <= S_OEND;
                end
                S_OEND: begin
                    if ((r_least == '1) || (ri_idx == SW'(SLOTS - 1))) begin
                        r_i     <= '0;
                        r_prevb <= '0;
                        r_st    <= S_ZOADR;
                    end else begin
                        r_i  <= r_i + 1'b1;
                        r_st <= S_OSTART;
                    end
                end
                S_ZOADR: begin
                    r_st <= S_ZORD;
                end
                S_ZORD: begin
                    r_s  <= ord_rdata;
                    r_st <= S_ZENT;
                end
                S_ZENT: begin
                    if (e_cnt == '0) begin
                        r_zones <= r_i;
                        r_done  <= 1'b1;
                        r_st    <= S_IDLE;
                    end else begin
                        r_lo   <= r_prevb;
                        r_best <= e_bnd;
                        r_curb <= e_bnd;
                        r_n    <= e_cnt;
                        r_k    <= '0;
                        r_kv   <= 1'b0;
                        r_st   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // One id read per cycle; the data of the previous read is compared here.
                    if (k_hit) begin
                        r_best <= id_rdata;
                    end
                    if (r_k < r_n) begin
                        r_k  <= r_k + 1'b1;
                        r_kv <= 1'b1;
                    end else begin
                        r_kv <= 1'b0;
                        r_st <= S_ZWR;
                    end
                end
                S_ZWR: begin
                    r_prevb <= r_curb;
                    if (ri_idx == SW'(SLOTS - 1)) begin
                        r_zones <= ZW'(SLOTS);
                        r_done  <= 1'b1;
                        r_st    <= S_IDLE;
                    end else begin
                        r_i  <= r_i + 1'b1;
                        r_st <= S_ZOADR;
                    end
                end
                S_QRY: begin
                    if (q_hit) begin
                        r_dead <= 1'b1;
                        r_done <= 1'b1;
                        r_st   <= S_IDLE;
                    end else if (r_qi < r_zones) begin
                        r_qi <= r_qi + 1'b1;
                        r_qv <= 1'b1;
                    end else begin
                        r_done <= 1'b1;
                        r_st   <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("result strobe held");
    a_zones_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_zones <= ZW'(SLOTS)) else $error("zone count out of range");
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_SCAN) |-> (r_k <= r_n) && (r_n != '0))
        else $error("id scan out of range");
    a_pop_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_st == S_DISP) else $error("popped transaction not dispatched");
endmodule

>>> rtl/version_dead_zone_engine_top.sv
`timescale 1ns / 1ps
// Top level of the version dead-zone engine: front queue plus execution engine.
// A transaction is taken when start is high and busy is low; each produces exactly one
// result, shown for one cycle with o_done high, and the receiver cannot stall it. A
// two-entry queue in front of the engine keeps accepting while the engine works, until
// it is full. Clear finishes at dispatch, add id and set bound after a read-modify-write
// of the slot entry. A query is decided by the age check or else by scanning the valid
// zones one by one through the single read port of the zone RAM. A zone build fills the
// order table, runs a selection sort of the slots by bound, then per zone scans the stored
// ids one by one through the single read port of the id RAM. Reset is immediate: the table
// is cleared through per-slot valid flags, with no clearing pass.
module version_dead_zone_engine_top #(
    parameter int SLOTS        = vdz_pkg::SLOTS_DEF,
    parameter int IDS_PER_SLOT = vdz_pkg::IDS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [vdz_pkg::OPW-1:0]    i_op,
    input  logic [vdz_pkg::SLOTW-1:0]  i_slot,
    input  logic [vdz_pkg::XW-1:0]     i_active_xid,
    input  logic [vdz_pkg::XW-1:0]     i_snapshot_bound,
    input  logic [vdz_pkg::XW-1:0]     i_version_begin,
    input  logic [vdz_pkg::XW-1:0]     i_version_end,
    input  logic [vdz_pkg::XW-1:0]     i_global_oldest,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [vdz_pkg::XW-1:0]     i_cfg_data,
    output logic                       o_done,
    output logic                       o_status,
    output logic                       o_is_dead,
    output logic [vdz_pkg::ZCW-1:0]    o_zone_count
);
    import vdz_pkg::*;

    t_cmd cmd;
    logic cmd_vld;
    logic pop;

    vdz_front #(.SLOTS(SLOTS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .o_busy(busy),
        .i_op(i_op), .i_slot(i_slot), .i_active_xid(i_active_xid),
        .i_snapshot_bound(i_snapshot_bound), .i_version_begin(i_version_begin),
        .i_version_end(i_version_end), .i_global_oldest(i_global_oldest),
        .o_cmd_vld(cmd_vld), .o_cmd(cmd), .i_pop(pop)
    );

    vdz_back #(.SLOTS(SLOTS), .IDS_PER_SLOT(IDS_PER_SLOT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_vld(cmd_vld), .i_cmd(cmd),
        .o_pop(pop), .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data), .o_done(o_done), .o_status(o_status),
        .o_is_dead(o_is_dead), .o_zone_count(o_zone_count)
    );
endmodule
